// ===== rtl/pladj_pkg.sv =====
// Shared types and constants for the pair-list to adjacency-table block.
// Holds the field widths, the action, status and register codes.
// No dependencies; every other file of the block imports it.
package pladj_pkg;

  // Fixed widths of the request and result fields.
  localparam int NODE_FIELD_W = 10;
  localparam int SLOT_FIELD_W = 3;
  localparam int ACTION_W     = 2;
  localparam int NCOUNT_W     = 11;
  localparam int NSLOTS_W     = 4;
  localparam int NB_W         = 11;

  // Neighbour value reported for an empty slot or a non-read request.
  localparam logic signed [NB_W-1:0] NB_EMPTY = -11'sd1;

  // Request actions; code 3 is unused and answers with an empty result.
  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_SLOTS      = 1'b1
  } cfg_reg_t;

endpackage

// ===== rtl/pladj_fill_store.sv =====
// Row fill store with the shared room-check and increment unit.
// One read and one write port; read data is registered.
// Depends on pladj_pkg.
module pladj_fill_store #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_SLOTS = 8,
  parameter int NODE_W    = $clog2(MAX_NODES),
  parameter int FILL_W    = $clog2(MAX_SLOTS + 1)
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [NODE_W-1:0]             rd_addr,
  input  logic                          wr_en,
  input  logic [NODE_W-1:0]             wr_addr,
  input  logic [FILL_W-1:0]             wr_data,
  input  logic [pladj_pkg::NSLOTS_W-1:0] slots_per_node,
  output logic [FILL_W-1:0]             rd_fill,
  output logic                          room,
  output logic [FILL_W-1:0]             fill_inc
);
  import pladj_pkg::*;

  logic [FILL_W-1:0] mem [MAX_NODES];

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_fill <= mem[rd_addr];
    end
  end

  // A row has room while its fill is below both the configured and the built slot count.
  assign room = (32'(rd_fill) < 32'(slots_per_node)) && (32'(rd_fill) < MAX_SLOTS);
  assign fill_inc = rd_fill + FILL_W'(1);

endmodule

// ===== rtl/pladj_table_ram.sv =====
// Neighbour table memory: one write port, one registered read port.
// Entries hold node indexes; contents are undefined until written.
// Depends on pladj_pkg.
module pladj_table_ram #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic [pladj_pkg::NODE_FIELD_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [ADDR_W-1:0]                 rd_addr,
  output logic [pladj_pkg::NODE_FIELD_W-1:0] rd_data
);
  import pladj_pkg::*;

  logic [NODE_FIELD_W-1:0] mem [DEPTH];

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/pladj_seq.sv =====
// Request sequencer: decodes a request, steps the fill store and table
// through the read-check-write order, and holds the result register.
// Depends on pladj_pkg.
module pladj_seq #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_SLOTS = 8,
  parameter int NODE_W    = $clog2(MAX_NODES),
  parameter int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  parameter int FILL_W    = $clog2(MAX_SLOTS + 1),
  parameter int TBL_AW    = NODE_W + SLOT_W
) (
  input  logic                                clk,
  input  logic                                rst,
  // Request side
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pladj_pkg::ACTION_W-1:0]      in_action,
  input  logic [pladj_pkg::NODE_FIELD_W-1:0]  in_first,
  input  logic [pladj_pkg::NODE_FIELD_W-1:0]  in_second,
  input  logic [pladj_pkg::SLOT_FIELD_W-1:0]  in_slot,
  // Configuration
  input  logic [pladj_pkg::NCOUNT_W-1:0]      node_count,
  // Fill store
  output logic                                fill_rd_en,
  output logic [NODE_W-1:0]                   fill_rd_addr,
  output logic                                fill_wr_en,
  output logic [NODE_W-1:0]                   fill_wr_addr,
  output logic [FILL_W-1:0]                   fill_wr_data,
  input  logic [FILL_W-1:0]                   fill_rd,
  input  logic                                fill_room,
  input  logic [FILL_W-1:0]                   fill_inc,
  // Neighbour table
  output logic                                tbl_wr_en,
  output logic [TBL_AW-1:0]                   tbl_wr_addr,
  output logic [pladj_pkg::NODE_FIELD_W-1:0]  tbl_wr_data,
  output logic                                tbl_rd_en,
  output logic [TBL_AW-1:0]                   tbl_rd_addr,
  input  logic [pladj_pkg::NODE_FIELD_W-1:0]  tbl_rd_data,
  // Result side
  output logic                                out_valid,
  input  logic                                out_ready,
  output pladj_pkg::status_t                  out_status,
  output logic signed [pladj_pkg::NB_W-1:0]   out_neighbour,
  output logic                                out_error
);
  import pladj_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ADD_B,
    S_ADD_CHK,
    S_ADD_WB,
    S_READ_CHK,
    S_DONE
  } state_t;

  state_t                    state;
  logic [ACTION_W-1:0]       act;
  logic [NODE_FIELD_W-1:0]   node_a;
  logic [NODE_FIELD_W-1:0]   node_b;
  logic [SLOT_FIELD_W-1:0]   slot;
  logic                      failed;
  logic [NODE_W-1:0]         clr_addr;
  logic                      clr_reply;
  status_t                   res_status;
  logic signed [NB_W-1:0]    res_nb;
  logic [FILL_W-1:0]         fill_a;
  logic [FILL_W-1:0]         fill_a_inc;
  logic                      room_a;
  logic [FILL_W-1:0]         fill_b;
  logic [FILL_W-1:0]         fill_b_inc;

  logic a_ok;
  logic b_ok;
  logic slot_ok;
  logic clr_last;

  // Node range checks against the configured and the built node count.
  assign a_ok = ({1'b0, node_a} < node_count) && (32'(node_a) < MAX_NODES);
  assign b_ok = ({1'b0, node_b} < node_count) && (32'(node_b) < MAX_NODES);
  // A read hits a stored entry only below the row fill and inside the row.
  assign slot_ok = (32'(slot) < 32'(fill_rd)) && (32'(slot) < MAX_SLOTS);
  assign clr_last = (clr_addr == NODE_W'(MAX_NODES - 1));

  assign in_ready = (state == S_IDLE);

  // Memory port control for each sequencer step.
  always_comb begin
    fill_rd_en   = 1'b0;
    fill_rd_addr = NODE_W'(node_a);
    fill_wr_en   = 1'b0;
    fill_wr_addr = clr_addr;
    fill_wr_data = '0;
    tbl_wr_en    = 1'b0;
    tbl_wr_addr  = {NODE_W'(node_a), SLOT_W'(fill_a)};
    tbl_wr_data  = node_b;
    tbl_rd_en    = 1'b0;
    tbl_rd_addr  = {NODE_W'(node_a), SLOT_W'(slot)};
    unique case (state)
      S_CLEAR: begin
        fill_wr_en = 1'b1;
      end
      S_DECODE: begin
        fill_rd_en = 1'b1;
        tbl_rd_en  = 1'b1;
      end
      S_ADD_B: begin
        fill_rd_en   = 1'b1;
        fill_rd_addr = NODE_W'(node_b);
      end
      S_ADD_CHK: begin
        if (room_a && fill_room) begin
          fill_wr_en   = 1'b1;
          fill_wr_addr = NODE_W'(node_a);
          fill_wr_data = fill_a_inc;
          tbl_wr_en    = 1'b1;
        end
      end
      S_ADD_WB: begin
        fill_wr_en   = 1'b1;
        fill_wr_addr = NODE_W'(node_b);
        fill_wr_data = fill_b_inc;
        tbl_wr_en    = 1'b1;
        tbl_wr_addr  = {NODE_W'(node_b), SLOT_W'(fill_b)};
        tbl_wr_data  = node_a;
      end
      S_IDLE, S_READ_CHK, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, working registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      failed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NODE_W'(1);
          if (clr_last) begin
            failed     <= 1'b0;
            res_status <= ST_OK;
            res_nb     <= NB_EMPTY;
            state      <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act    <= in_action;
            node_a <= in_first;
            node_b <= in_second;
            slot   <= in_slot;
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_status <= ST_OK;
          res_nb     <= NB_EMPTY;
          state      <= S_DONE;
          case (act)
            ACT_CLEAR: begin
              clr_addr  <= '0;
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end
            ACT_ADD: begin
              priority if (failed) begin
                res_status <= ST_REFUSED;
              end else if (!a_ok || !b_ok) begin
                res_status <= ST_RANGE;
                failed     <= 1'b1;
              end else begin
                state <= S_ADD_B;
              end
            end
            ACT_READ: begin
              if (!a_ok) begin
                res_status <= ST_RANGE;
              end else begin
                state <= S_READ_CHK;
              end
            end
            default: begin
            end
          endcase
        end
        S_ADD_B: begin
          fill_a     <= fill_rd;
          fill_a_inc <= fill_inc;
          room_a     <= fill_room;
          state      <= S_ADD_CHK;
        end
        S_ADD_CHK: begin
          fill_b     <= fill_rd;
          fill_b_inc <= fill_inc;
          if (!(room_a && fill_room)) begin
            res_status <= ST_FULL;
            failed     <= 1'b1;
            state      <= S_DONE;
          end else if (node_a == node_b) begin
            state <= S_DONE;
          end else begin
            state <= S_ADD_WB;
          end
        end
        S_ADD_WB: begin
          state <= S_DONE;
        end
        S_READ_CHK: begin
          if (slot_ok) begin
            res_nb <= $signed({1'b0, tbl_rd_data});
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            out_status    <= res_status;
            out_neighbour <= res_nb;
            out_error     <= failed;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/pair_list_to_adjacency_table.sv =====
// Adjacency table builder: after reset the fill store is swept to zero one
// row per cycle, during which no request is taken (configuration writes
// are). Each request is then handled alone by a sequencer that steps a fill
// store with one read and one write port and its room-check unit. A request
// is decoded and range checked; an add then reads the second node's fill,
// checks room in both rows and writes the first row's fill and entry, then
// the second row's (a self loop stops after the first, a full row after the
// check); a read checks its slot against the row fill; a clear repeats the
// sweep. While an earlier result is still held by the consumer, the last
// step waits for the output register to free up. A new request is taken the
// cycle after the result enters the output register. Contents of the
// neighbour table are only ever used below a row's fill, so that memory
// needs no clearing.
// Top level: configuration registers, stream packing and the three units.
// Depends on pladj_pkg, pladj_seq, pladj_fill_store and pladj_table_ram.
module pair_list_to_adjacency_table #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // Request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // first_node, second_node, slot_index, pad
  input  logic [pladj_pkg::ACTION_W-1:0] s_tuser,  // action
  // Result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // neighbour, error_seen, pad
  output logic [1:0]                    m_tuser,   // status
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [pladj_pkg::NCOUNT_W-1:0] cfg_data
);
  import pladj_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int FILL_W = $clog2(MAX_SLOTS + 1);
  localparam int TBL_AW = NODE_W + SLOT_W;
  localparam int TBL_DEPTH = MAX_NODES << SLOT_W;

  logic [NCOUNT_W-1:0] node_count;
  logic [NSLOTS_W-1:0] slots_per_node;

  logic                    fill_rd_en;
  logic [NODE_W-1:0]       fill_rd_addr;
  logic                    fill_wr_en;
  logic [NODE_W-1:0]       fill_wr_addr;
  logic [FILL_W-1:0]       fill_wr_data;
  logic [FILL_W-1:0]       fill_rd;
  logic                    fill_room;
  logic [FILL_W-1:0]       fill_inc;
  logic                    tbl_wr_en;
  logic [TBL_AW-1:0]       tbl_wr_addr;
  logic [NODE_FIELD_W-1:0] tbl_wr_data;
  logic                    tbl_rd_en;
  logic [TBL_AW-1:0]       tbl_rd_addr;
  logic [NODE_FIELD_W-1:0] tbl_rd_data;
  status_t                 out_status;
  logic signed [NB_W-1:0]  out_neighbour;
  logic                    out_error;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count     <= NCOUNT_W'(1);
      slots_per_node <= NSLOTS_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NODE_COUNT: node_count     <= cfg_data;
        CFG_SLOTS:      slots_per_node <= cfg_data[NSLOTS_W-1:0];
      endcase
    end
  end

  // Result packing.
  assign m_tdata = {4'd0, out_error, out_neighbour};
  assign m_tuser = out_status;

  pladj_seq #(
    .MAX_NODES (MAX_NODES),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_action     (s_tuser),
    .in_first      (s_tdata[9:0]),
    .in_second     (s_tdata[19:10]),
    .in_slot       (s_tdata[22:20]),
    .node_count    (node_count),
    .fill_rd_en    (fill_rd_en),
    .fill_rd_addr  (fill_rd_addr),
    .fill_wr_en    (fill_wr_en),
    .fill_wr_addr  (fill_wr_addr),
    .fill_wr_data  (fill_wr_data),
    .fill_rd       (fill_rd),
    .fill_room     (fill_room),
    .fill_inc      (fill_inc),
    .tbl_wr_en     (tbl_wr_en),
    .tbl_wr_addr   (tbl_wr_addr),
    .tbl_wr_data   (tbl_wr_data),
    .tbl_rd_en     (tbl_rd_en),
    .tbl_rd_addr   (tbl_rd_addr),
    .tbl_rd_data   (tbl_rd_data),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_status    (out_status),
    .out_neighbour (out_neighbour),
    .out_error     (out_error)
  );

  pladj_fill_store #(
    .MAX_NODES (MAX_NODES),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_fill (
    .clk            (clk),
    .rd_en          (fill_rd_en),
    .rd_addr        (fill_rd_addr),
    .wr_en          (fill_wr_en),
    .wr_addr        (fill_wr_addr),
    .wr_data        (fill_wr_data),
    .slots_per_node (slots_per_node),
    .rd_fill        (fill_rd),
    .room           (fill_room),
    .fill_inc       (fill_inc)
  );

  pladj_table_ram #(
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

endmodule
